// File: sv/vpt_pkg.sv
// Shared types and constants for the vector parallel transport pipeline.
`timescale 1ns / 1ps

package vpt_pkg;

    localparam int WORD_BITS  = 32;            // word width of every input and output vector component
    localparam int FRAC_BITS  = 16;            // fraction bits of the words
    localparam int UNIT_BITS  = 30;            // fraction bits of unit vectors
    localparam int E_W        = UNIT_BITS + 2; // width of a unit-vector component
    localparam int N_IT       = UNIT_BITS + 2; // root and quotient iterations
    localparam int N_ST       = N_IT / 2;      // two iterations per stage
    localparam int NORM_LAT   = 4 + 2 * N_ST;  // latency of one normalizer
    localparam int CROSS_LAT  = 2;             // latency of one cross product
    localparam int MODE_W     = 2;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_FULL   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_ORTHO  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 1'b0,
        REG_THRESH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] u_x;
        logic signed [WORD_BITS-1:0] u_y;
        logic signed [WORD_BITS-1:0] u_z;
        logic signed [WORD_BITS-1:0] from_x;
        logic signed [WORD_BITS-1:0] from_y;
        logic signed [WORD_BITS-1:0] from_z;
        logic signed [WORD_BITS-1:0] to_x;
        logic signed [WORD_BITS-1:0] to_y;
        logic signed [WORD_BITS-1:0] to_z;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] out_x;
        logic signed [WORD_BITS-1:0] out_y;
        logic signed [WORD_BITS-1:0] out_z;
        logic                        was_collinear;
    } t_out_word;

endpackage

// File: sv/vpt_delay.sv
// Enabled shift line that keeps side data in step with the pipeline.
`timescale 1ns / 1ps

module vpt_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[N-1];

endmodule

// File: sv/vpt_cross.sv
// Two-stage exact cross product: products, then differences.
`timescale 1ns / 1ps

module vpt_cross #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a [3],
    input  logic signed [BW-1:0]    i_b [3],
    output logic signed [AW+BW:0]   o_c [3]
);

    logic signed [AW+BW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_a[1] * i_b[2];
            r_p[1] <= i_a[2] * i_b[1];
            r_p[2] <= i_a[2] * i_b[0];
            r_p[3] <= i_a[0] * i_b[2];
            r_p[4] <= i_a[0] * i_b[1];
            r_p[5] <= i_a[1] * i_b[0];
            for (int i = 0; i < 3; i++) begin
                o_c[i] <= (AW+BW+1)'(r_p[2*i]) - (AW+BW+1)'(r_p[2*i+1]);
            end
        end
    end

endmodule

// File: sv/vpt_norm.sv
// Pipelined normalizer: scale, sum of squares, integer root, three quotients.
`timescale 1ns / 1ps

module vpt_norm #(
    parameter int IN_W = 65
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [IN_W-1:0]          i_v [3],
    output logic signed [vpt_pkg::E_W-1:0]  o_e [3]
);

    import vpt_pkg::*;

    localparam int SW   = (IN_W > UNIT_BITS) ? IN_W : UNIT_BITS;
    localparam int XW   = 2 * UNIT_BITS + 4;
    localparam int RW   = E_W;
    localparam int RMW  = RW + 2;
    localparam int LAST = N_ST - 1;

    // stage 1: magnitudes
    logic [IN_W-1:0] r_m1 [3];
    logic [2:0]      r_neg1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_m1[i]   <= i_v[i][IN_W-1] ? $unsigned(-i_v[i]) : $unsigned(i_v[i]);
                r_neg1[i] <= i_v[i][IN_W-1];
            end
        end
    end

    // stage 2: bring the largest magnitude into [2^29, 2^30)
    logic [UNIT_BITS-1:0] n_s2 [3];
    logic                 n_z2;
    logic [UNIT_BITS-1:0] r_s2 [3];
    logic [2:0]           r_neg2;
    logic                 r_z2;

    always_comb begin
        logic [IN_W-1:0] orv;
        logic [SW-1:0]   tmp;
        int              len;
        orv = r_m1[0] | r_m1[1] | r_m1[2];
        len = 0;
        for (int k = 0; k < IN_W; k++) begin
            if (orv[k]) len = k + 1;
        end
        n_z2 = (len == 0);
        for (int i = 0; i < 3; i++) begin
            tmp = SW'(r_m1[i]);
            if (len > UNIT_BITS) tmp = tmp >> (len - UNIT_BITS);
            else tmp = tmp << (UNIT_BITS - len);
            n_s2[i] = tmp[UNIT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2   <= n_s2;
            r_z2   <= n_z2;
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: squares, stage 4: sum
    logic [2*UNIT_BITS-1:0] r_sq3 [3];
    logic [UNIT_BITS-1:0]   r_s3 [3];
    logic [2:0]             r_neg3;
    logic                   r_z3;
    logic [XW-1:0]          r_x4;
    logic [UNIT_BITS-1:0]   r_s4 [3];
    logic [2:0]             r_neg4;
    logic                   r_z4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq3[i] <= r_s2[i] * r_s2[i];
            end
            r_s3   <= r_s2;
            r_neg3 <= r_neg2;
            r_z3   <= r_z2;
            r_x4   <= XW'(r_sq3[0]) + XW'(r_sq3[1]) + XW'(r_sq3[2]);
            r_s4   <= r_s3;
            r_neg4 <= r_neg3;
            r_z4   <= r_z3;
        end
    end

    // integer square root, two result bits per stage
    logic [XW-1:0]        r_qx [N_ST];
    logic [XW-1:0]        r_qr [N_ST];
    logic [UNIT_BITS-1:0] r_qs [N_ST][3];
    logic [2:0]           r_qn [N_ST];
    logic                 r_qz [N_ST];

    for (genvar g = 0; g < N_ST; g++) begin : g_sq
        logic [XW-1:0]        x_in;
        logic [XW-1:0]        rt_in;
        logic [UNIT_BITS-1:0] s_in [3];
        logic [2:0]           neg_in;
        logic                 z_in;
        logic [XW-1:0]        n_qx;
        logic [XW-1:0]        n_qr;

        if (g == 0) begin : g_first
            assign x_in   = r_x4;
            assign rt_in  = '0;
            assign s_in   = r_s4;
            assign neg_in = r_neg4;
            assign z_in   = r_z4;
        end else begin : g_rest
            assign x_in   = r_qx[g-1];
            assign rt_in  = r_qr[g-1];
            assign s_in   = r_qs[g-1];
            assign neg_in = r_qn[g-1];
            assign z_in   = r_qz[g-1];
        end

        always_comb begin
            logic [XW-1:0] bv;
            n_qx = x_in;
            n_qr = rt_in;
            for (int j = 0; j < 2; j++) begin
                bv = XW'(1) << (2 * N_IT - 2 - 2 * (2 * g + j));
                if (n_qx >= n_qr + bv) begin
                    n_qx = n_qx - (n_qr + bv);
                    n_qr = (n_qr >> 1) + bv;
                end else begin
                    n_qr = n_qr >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qx[g] <= n_qx;
                r_qr[g] <= n_qr;
                r_qs[g] <= s_in;
                r_qn[g] <= neg_in;
                r_qz[g] <= z_in;
            end
        end
    end

    // restoring division (s << 30) / norm, two quotient bits per stage
    logic [RMW-1:0]       r_drem [N_ST][3];
    logic [RW-1:0]        r_dq   [N_ST][3];
    logic [UNIT_BITS-1:0] r_ds   [N_ST][3];
    logic [RW-1:0]        r_dnrm [N_ST];
    logic [2:0]           r_dn   [N_ST];
    logic                 r_dz   [N_ST];
    logic signed [E_W-1:0] r_e [3];

    for (genvar g = 0; g < N_ST; g++) begin : g_div
        logic [RMW-1:0]       rem_in [3];
        logic [RW-1:0]        q_in   [3];
        logic [UNIT_BITS-1:0] s_in   [3];
        logic [RW-1:0]        nrm_in;
        logic [2:0]           neg_in;
        logic                 z_in;
        logic [RMW-1:0]       n_rem  [3];
        logic [RW-1:0]        n_q    [3];

        if (g == 0) begin : g_first
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_in[i] = RMW'(r_qs[LAST][i] >> (N_IT - UNIT_BITS));
                    q_in[i]   = '0;
                end
            end
            assign s_in   = r_qs[LAST];
            assign nrm_in = r_qr[LAST][RW-1:0];
            assign neg_in = r_qn[LAST];
            assign z_in   = r_qz[LAST];
        end else begin : g_rest
            assign rem_in = r_drem[g-1];
            assign q_in   = r_dq[g-1];
            assign s_in   = r_ds[g-1];
            assign nrm_in = r_dnrm[g-1];
            assign neg_in = r_dn[g-1];
            assign z_in   = r_dz[g-1];
        end

        always_comb begin
            logic db;
            int   jb;
            for (int i = 0; i < 3; i++) begin
                n_rem[i] = rem_in[i];
                n_q[i]   = q_in[i];
                for (int j = 0; j < 2; j++) begin
                    jb = N_IT - 1 - (2 * g + j);
                    db = 1'b0;
                    if (jb >= UNIT_BITS) db = s_in[i][jb-UNIT_BITS];
                    n_rem[i] = {n_rem[i][RMW-2:0], db};
                    if (n_rem[i] >= RMW'(nrm_in)) begin
                        n_rem[i]   = n_rem[i] - RMW'(nrm_in);
                        n_q[i][jb] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[g] <= n_rem;
                r_dq[g]   <= n_q;
                r_ds[g]   <= s_in;
                r_dnrm[g] <= nrm_in;
                r_dn[g]   <= neg_in;
                r_dz[g]   <= z_in;
            end
        end

        if (g == LAST) begin : g_out
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int i = 0; i < 3; i++) begin
                        if (z_in) r_e[i] <= '0;
                        else if (neg_in[i]) r_e[i] <= -$signed(E_W'(n_q[i]));
                        else r_e[i] <= $signed(E_W'(n_q[i]));
                    end
                end
            end
        end
    end

    assign o_e = r_e;

endmodule

// File: sv/vector_parallel_transport.sv
// Top level of the vector parallel transport pipeline.
`timescale 1ns / 1ps

// Rotates u about b = from x to so that the source tangent lands on the target
// tangent, one word in and one word out per clock unless the output is held.
// The pipeline runs through two normalizers in series (each: scaling, sum of
// squares, a 16-stage integer root and a 16-stage divider at two bits per
// stage), two cross products, then projection and recombination. Every
// stage carries a valid bit; when the output word is held by the consumer the
// whole pipeline freezes, so nothing is dropped or repeated, and o_in_ready is
// high whenever the output register is empty or being taken. Register 0 selects
// the mode (full, normal part only, orthonormal; 3 acts as orthonormal) and
// register 1 the collinear threshold in unsigned Q0.16; both are read live and
// must be written only while the pipeline is empty. Collinear words pass u
// through unchanged with was_collinear set; all other results saturate to
// Q16.16.
module vector_parallel_transport (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  vpt_pkg::t_in_word                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output vpt_pkg::t_out_word                 o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vpt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import vpt_pkg::*;

    localparam int W      = WORD_BITS;
    localparam int CW     = 2 * W + 1;           // cross of two words
    localparam int NW     = W + E_W + 1;         // cross of a word and a unit vector
    localparam int UW     = 2 * E_W + 1;         // cross of two unit vectors
    localparam int ON_W   = NW - UNIT_BITS;      // unnormalized frame normal
    localparam int LIM_W  = THRESH_W + FRAC_BITS;
    localparam int BSQ_W  = 2 * (LIM_W + 2);
    localparam int BSUM_W = BSQ_W + 2;
    localparam int PN_W   = W + ON_W;
    localparam int PB_W   = W + E_W;
    localparam int CN_W   = PN_W + 2 - FRAC_BITS;
    localparam int CB_W   = PB_W + 2 - UNIT_BITS;
    localparam int LO_W   = 25;
    localparam int HI_W   = CN_W - LO_W;
    localparam int SUM_W  = CN_W + ON_W + 2;

    localparam int ST_B    = CROSS_LAT;
    localparam int ST_COLL = ST_B + 2;
    localparam int ST_BH   = ST_B + NORM_LAT;
    localparam int ST_W    = ST_BH + CROSS_LAT;
    localparam int ST_N    = ST_W + NORM_LAT;
    localparam int ST_OUT  = ST_N + 5;

    logic en;
    logic [ST_OUT:1] r_vld;
    logic [MODE_W-1:0]   r_mode;
    logic [THRESH_W-1:0] r_thresh;

    // pipeline advances unless the output word is stuck
    assign en          = !r_vld[ST_OUT] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[ST_OUT];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-1:1], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FULL;
            r_thresh <= THRESH_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_THRESH: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // input word unpacked
    logic signed [W-1:0] u0  [3];
    logic signed [W-1:0] t00 [3];
    logic signed [W-1:0] t10 [3];

    assign u0[0]  = i_in.u_x;
    assign u0[1]  = i_in.u_y;
    assign u0[2]  = i_in.u_z;
    assign t00[0] = i_in.from_x;
    assign t00[1] = i_in.from_y;
    assign t00[2] = i_in.from_z;
    assign t10[0] = i_in.to_x;
    assign t10[1] = i_in.to_y;
    assign t10[2] = i_in.to_z;

    // binormal b = t0 x t1, exact
    logic signed [CW-1:0] b [3];

    vpt_cross #(.AW(W), .BW(W)) u_cross_b (
        .i_clk(i_clk), .i_en(en), .i_a(t00), .i_b(t10), .o_c(b)
    );

    // collinear test: every |b_i| below the limit, then |b|^2 below limit^2
    logic                    n_ok3;
    logic                    r_ok3;
    logic [BSQ_W-1:0]        r_bsq3 [3];
    logic [2*LIM_W-1:0]      r_limsq3;
    logic                    r_coll4;
    logic [LIM_W-1:0]        lim;

    assign lim = {r_thresh, FRAC_BITS'(0)};

    always_comb begin
        logic [CW-1:0] mag;
        n_ok3 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            mag = b[i][CW-1] ? $unsigned(-b[i]) : $unsigned(b[i]);
            if (!(mag < CW'(lim))) n_ok3 = 1'b0;
        end
    end

    // squares are signed: low bits of b hold the full value once each |b_i| is small
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok3 <= n_ok3;
            for (int i = 0; i < 3; i++) begin
                r_bsq3[i] <= $unsigned($signed(b[i][LIM_W+1:0]) * $signed(b[i][LIM_W+1:0]));
            end
            r_limsq3 <= lim * lim;
            r_coll4  <= r_ok3 && ((BSUM_W'(r_bsq3[0]) + BSUM_W'(r_bsq3[1])
                        + BSUM_W'(r_bsq3[2])) < BSUM_W'(r_limsq3));
        end
    end

    // unit binormal
    logic signed [E_W-1:0] bh [3];

    vpt_norm #(.IN_W(CW)) u_norm_b (.i_clk(i_clk), .i_en(en), .i_v(b), .o_e(bh));

    // tangents aligned with b, then unit tangents
    logic [6*W-1:0] t_pk0, t_pk2, t_pk38;
    logic signed [W-1:0] t02 [3], t12 [3], t038 [3], t138 [3];
    logic signed [E_W-1:0] th0 [3], th1 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_pk0[i*W +: W]     = t00[i];
            t_pk0[(i+3)*W +: W] = t10[i];
            t02[i]  = $signed(t_pk2[i*W +: W]);
            t12[i]  = $signed(t_pk2[(i+3)*W +: W]);
            t038[i] = $signed(t_pk38[i*W +: W]);
            t138[i] = $signed(t_pk38[(i+3)*W +: W]);
        end
    end

    vpt_delay #(.W(6*W), .N(ST_B)) u_dly_t2 (
        .i_clk(i_clk), .i_en(en), .i_d(t_pk0), .o_q(t_pk2)
    );
    vpt_delay #(.W(6*W), .N(ST_BH - ST_B)) u_dly_t38 (
        .i_clk(i_clk), .i_en(en), .i_d(t_pk2), .o_q(t_pk38)
    );

    vpt_norm #(.IN_W(W)) u_norm_t0 (.i_clk(i_clk), .i_en(en), .i_v(t02), .o_e(th0));
    vpt_norm #(.IN_W(W)) u_norm_t1 (.i_clk(i_clk), .i_en(en), .i_v(t12), .o_e(th1));

    // frame normals: unit tangent x unit binormal, and the raw tangent form
    logic signed [UW-1:0] wn0 [3], wn1 [3];
    logic signed [NW-1:0] wo0 [3], wo1 [3];

    vpt_cross #(.AW(E_W), .BW(E_W)) u_cross_n0 (
        .i_clk(i_clk), .i_en(en), .i_a(th0), .i_b(bh), .o_c(wn0)
    );
    vpt_cross #(.AW(E_W), .BW(E_W)) u_cross_n1 (
        .i_clk(i_clk), .i_en(en), .i_a(th1), .i_b(bh), .o_c(wn1)
    );
    vpt_cross #(.AW(W), .BW(E_W)) u_cross_o0 (
        .i_clk(i_clk), .i_en(en), .i_a(t038), .i_b(bh), .o_c(wo0)
    );
    vpt_cross #(.AW(W), .BW(E_W)) u_cross_o1 (
        .i_clk(i_clk), .i_en(en), .i_a(t138), .i_b(bh), .o_c(wo1)
    );

    logic signed [E_W-1:0] n0h [3], n1h [3];

    vpt_norm #(.IN_W(UW)) u_norm_n0 (.i_clk(i_clk), .i_en(en), .i_v(wn0), .o_e(n0h));
    vpt_norm #(.IN_W(UW)) u_norm_n1 (.i_clk(i_clk), .i_en(en), .i_v(wn1), .o_e(n1h));

    // side data brought up to the normal stage
    logic [6*ON_W-1:0] on_pk, on_pkd;
    logic [9*E_W-1:0]  ub_pk, ub_pkd;
    logic [3*W-1:0]    u_pk, u_pkd;
    logic              coll_d;
    logic signed [ON_W-1:0] no0 [3], no1 [3];
    logic signed [E_W-1:0]  bhd [3], th0d [3], th1d [3];
    logic signed [W-1:0]    ud [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            on_pk[i*ON_W +: ON_W]     = wo0[i][NW-1:UNIT_BITS];
            on_pk[(i+3)*ON_W +: ON_W] = wo1[i][NW-1:UNIT_BITS];
            ub_pk[i*E_W +: E_W]       = bh[i];
            ub_pk[(i+3)*E_W +: E_W]   = th0[i];
            ub_pk[(i+6)*E_W +: E_W]   = th1[i];
            u_pk[i*W +: W]            = u0[i];
            no0[i]  = $signed(on_pkd[i*ON_W +: ON_W]);
            no1[i]  = $signed(on_pkd[(i+3)*ON_W +: ON_W]);
            bhd[i]  = $signed(ub_pkd[i*E_W +: E_W]);
            th0d[i] = $signed(ub_pkd[(i+3)*E_W +: E_W]);
            th1d[i] = $signed(ub_pkd[(i+6)*E_W +: E_W]);
            ud[i]   = $signed(u_pkd[i*W +: W]);
        end
    end

    vpt_delay #(.W(6*ON_W), .N(ST_N - ST_W)) u_dly_on (
        .i_clk(i_clk), .i_en(en), .i_d(on_pk), .o_q(on_pkd)
    );
    vpt_delay #(.W(9*E_W), .N(ST_N - ST_BH)) u_dly_ub (
        .i_clk(i_clk), .i_en(en), .i_d(ub_pk), .o_q(ub_pkd)
    );
    vpt_delay #(.W(3*W), .N(ST_N)) u_dly_u (
        .i_clk(i_clk), .i_en(en), .i_d(u_pk), .o_q(u_pkd)
    );
    vpt_delay #(.W(1), .N(ST_N - ST_COLL)) u_dly_coll (
        .i_clk(i_clk), .i_en(en), .i_d(r_coll4), .o_q(coll_d)
    );

    // projection: products, coefficients, scaled frame, sum, saturate
    logic ortho, keep_tan;
    logic signed [ON_W-1:0] n0s [3], n1s [3];

    assign ortho    = (r_mode >= MODE_ORTHO);
    assign keep_tan = (r_mode == MODE_FULL);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n0s[i] = ortho ? no0[i] : ON_W'(n0h[i]);
            n1s[i] = ortho ? no1[i] : ON_W'(n1h[i]);
        end
    end

    logic signed [PN_W-1:0] r_pn1 [3];
    logic signed [PB_W-1:0] r_pb1 [3], r_pt1 [3];
    logic signed [ON_W-1:0] r_n1_1 [3], r_n1_2 [3];
    logic signed [E_W-1:0]  r_bh1 [3], r_th1_1 [3], r_bh2 [3], r_th1_2 [3];
    logic signed [W-1:0]    r_u1 [3], r_u2 [3], r_u3 [3], r_u4 [3];
    logic                   r_coll1, r_coll2, r_coll3, r_coll4b;
    logic                   r_ortho1, r_ortho2, r_ortho3, r_keep1;
    logic signed [CN_W-1:0] r_cn2;
    logic signed [CB_W-1:0] r_cb2, r_ct2;
    logic signed [HI_W+ON_W-1:0] r_ph3 [3];
    logic signed [LO_W+ON_W:0]   r_pl3 [3];
    logic signed [CB_W+E_W-1:0]  r_pb3 [3], r_pt3 [3];
    logic signed [SUM_W-1:0]     r_sum4 [3];
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pn1[i]   <= ud[i] * n0s[i];
                r_pb1[i]   <= ud[i] * bhd[i];
                r_pt1[i]   <= ud[i] * th0d[i];
            end
            r_n1_1   <= n1s;
            r_bh1    <= bhd;
            r_th1_1  <= th1d;
            r_u1     <= ud;
            r_coll1  <= coll_d;
            r_ortho1 <= ortho;
            r_keep1  <= keep_tan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ortho1) begin
                r_cn2 <= CN_W'((PN_W+2)'(r_pn1[0]) + (PN_W+2)'(r_pn1[1])
                         + (PN_W+2)'(r_pn1[2]) >>> FRAC_BITS);
            end else begin
                r_cn2 <= CN_W'((PN_W+2)'(r_pn1[0]) + (PN_W+2)'(r_pn1[1])
                         + (PN_W+2)'(r_pn1[2]) >>> UNIT_BITS);
            end
            r_cb2 <= CB_W'((PB_W+2)'(r_pb1[0]) + (PB_W+2)'(r_pb1[1])
                     + (PB_W+2)'(r_pb1[2]) >>> UNIT_BITS);
            if (r_keep1) begin
                r_ct2 <= CB_W'((PB_W+2)'(r_pt1[0]) + (PB_W+2)'(r_pt1[1])
                         + (PB_W+2)'(r_pt1[2]) >>> UNIT_BITS);
            end else begin
                r_ct2 <= '0;
            end
            r_n1_2   <= r_n1_1;
            r_bh2    <= r_bh1;
            r_th1_2  <= r_th1_1;
            r_u2     <= r_u1;
            r_coll2  <= r_coll1;
            r_ortho2 <= r_ortho1;
        end
    end

    // cn is split so each multiplier stays near 32 bits
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ph3[i] <= $signed(r_cn2[CN_W-1:LO_W]) * r_n1_2[i];
                r_pl3[i] <= $signed({1'b0, r_cn2[LO_W-1:0]}) * r_n1_2[i];
                r_pb3[i] <= r_cb2 * r_bh2[i];
                r_pt3[i] <= r_ct2 * r_th1_2[i];
            end
            r_u3     <= r_u2;
            r_coll3  <= r_coll2;
            r_ortho3 <= r_ortho2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_ortho3) begin
                    r_sum4[i] <= ((SUM_W'(r_ph3[i]) <<< LO_W) + SUM_W'(r_pl3[i]) >>> FRAC_BITS)
                                 + SUM_W'(r_pb3[i] >>> UNIT_BITS)
                                 + SUM_W'(r_pt3[i] >>> UNIT_BITS);
                end else begin
                    r_sum4[i] <= ((SUM_W'(r_ph3[i]) <<< LO_W) + SUM_W'(r_pl3[i]) >>> UNIT_BITS)
                                 + SUM_W'(r_pb3[i] >>> UNIT_BITS)
                                 + SUM_W'(r_pt3[i] >>> UNIT_BITS);
                end
            end
            r_u4     <= r_u3;
            r_coll4b <= r_coll3;
        end
    end

    // saturate to a word, or pass u through when collinear
    logic signed [W-1:0] sat [3];

    always_comb begin
        logic [SUM_W-W:0] top;
        for (int i = 0; i < 3; i++) begin
            top = r_sum4[i][SUM_W-1:W-1];
            if ((&top) || !(|top)) sat[i] = r_sum4[i][W-1:0];
            else if (r_sum4[i][SUM_W-1]) sat[i] = {1'b1, {(W-1){1'b0}}};
            else sat[i] = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_x         <= r_coll4b ? r_u4[0] : sat[0];
            r_out.out_y         <= r_coll4b ? r_u4[1] : sat[1];
            r_out.out_z         <= r_coll4b ? r_u4[2] : sat[2];
            r_out.was_collinear <= r_coll4b;
        end
    end

    assign o_out = r_out;

endmodule
